/* src/pidc_pkg.sv */
// Package for the clamped PID controller: register indexes, datapath commands,
// and shared width and divider constants. No dependencies.
`timescale 1ns / 1ps

package pidc_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned StepW = 31;
	localparam int unsigned IndexW = 3;

	typedef enum logic [IndexW-1:0] {
		REG_GAIN_P     = 3'd0,
		REG_GAIN_I     = 3'd1,
		REG_GAIN_D     = 3'd2,
		REG_TIME_STEP  = 3'd3,
		REG_LIMIT_LOW  = 3'd4,
		REG_LIMIT_HIGH = 3'd5
	} reg_index_t;

	// Operations the controller hands to the datapath.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,      // form and latch the error
		OP_MUL_EDT,   // error * time_step
		OP_MUL_INC,   // previous product * gain_i
		OP_INTEG,     // integral update and clamp
		OP_DIV_START, // load the divider
		OP_DIV_STEP,  // one quotient bit
		OP_DIV_END,   // sign and saturate the quotient
		OP_MUL_P,     // gain_p * error
		OP_MUL_D,     // gain_d * derivative
		OP_SUM        // final sum, clamp, store error
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic div_last;
	} dp_status_t;

	localparam int unsigned DivBits = 48;
	localparam int unsigned DivCntW = 6;

endpackage

/* src/pidc_stream_if.sv */
// Valid/ready channel carrying one word of a given payload width.
// Depends on nothing.
`timescale 1ns / 1ps

interface pidc_stream_if #(
	parameter int unsigned Width = 32
);
	logic valid;
	logic ready;
	logic [Width-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/pidc_datapath.sv */
// Arithmetic datapath of the PID controller: one shared multiplier, a restoring
// divider that yields one quotient bit a cycle, and the state registers. Uses pidc_pkg.
`timescale 1ns / 1ps

module pidc_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pidc_pkg::dp_cmd_t       cmd,
	output pidc_pkg::dp_status_t    status,
	input  logic signed [31:0]      measured,
	input  logic signed [31:0]      target,
	input  logic signed [31:0]      gain_p,
	input  logic signed [31:0]      gain_i,
	input  logic signed [31:0]      gain_d,
	input  logic [30:0]             time_step,
	input  logic signed [31:0]      limit_low,
	input  logic signed [31:0]      limit_high,
	output logic signed [31:0]      drive
);

	logic signed [31:0] error_q;
	logic signed [31:0] prev_error_q;
	logic signed [31:0] integral_q;
	logic signed [31:0] prod_q;
	logic signed [31:0] term_p_q;
	logic signed [31:0] deriv_q;
	logic signed [31:0] drive_q;
	logic [47:0] div_rem_q;
	logic [47:0] div_num_q;
	logic [47:0] div_quo_q;
	logic        div_neg_q;
	logic [pidc_pkg::DivCntW-1:0] div_cnt_q;

	logic [30:0] dt;
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] mul_p;
	logic signed [47:0] mul_sh;
	logic signed [31:0] mul_sat;
	logic signed [32:0] err_wide;
	logic signed [31:0] err_sat;
	logic signed [32:0] integ_wide;
	logic signed [31:0] integ_sat;
	logic signed [31:0] integ_clamp;
	logic signed [32:0] diff;
	logic [31:0] diff_mag;
	logic [48:0] rem_shift;
	logic [48:0] rem_trial;
	logic signed [48:0] quo_signed;
	logic signed [31:0] quo_sat;
	logic signed [33:0] sum_wide;
	logic signed [31:0] sum_clamp;

	function automatic logic signed [31:0] sat_to32(input logic signed [48:0] v);
		logic signed [31:0] r;
		if (v > 49'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -49'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] clamp_lim(input logic signed [33:0] v,
			input logic signed [31:0] lo, input logic signed [31:0] hi);
		logic signed [31:0] r;
		if (v > 34'(hi)) begin
			r = hi;
		end else if (v < 34'(lo)) begin
			r = lo;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	assign dt = (time_step == '0) ? 31'd1 : time_step;

	always_comb begin
		case (cmd.op)
			pidc_pkg::OP_MUL_EDT: begin mul_a = error_q; mul_b = $signed({1'b0, dt}); end
			pidc_pkg::OP_MUL_INC: begin mul_a = prod_q;  mul_b = gain_i; end
			pidc_pkg::OP_MUL_P:   begin mul_a = gain_p;  mul_b = error_q; end
			pidc_pkg::OP_MUL_D:   begin mul_a = gain_d;  mul_b = deriv_q; end
			default:              begin mul_a = error_q; mul_b = gain_p; end
		endcase
	end

	// Arithmetic shift floors, which matches rounding toward minus infinity.
	assign mul_p = mul_a * mul_b;
	assign mul_sh = mul_p[63:16];
	assign mul_sat = sat_to32(49'(mul_sh));

	assign err_wide = 33'(target) - 33'(measured);
	assign err_sat = sat_to32(49'(err_wide));

	assign integ_wide = 33'(integral_q) + 33'(prod_q);
	assign integ_sat = sat_to32(49'(integ_wide));
	assign integ_clamp = clamp_lim(34'(integ_sat), limit_low, limit_high);

	// Both errors are saturated, so the difference magnitude fits in 32 bits.
	assign diff = 33'(error_q) - 33'(prev_error_q);
	assign diff_mag = diff[32] ? 32'(-diff) : diff[31:0];

	assign rem_shift = {div_rem_q, div_num_q[47]};
	assign rem_trial = rem_shift - 49'({18'd0, dt});

	assign quo_signed = div_neg_q ? -$signed({1'b0, div_quo_q}) : $signed({1'b0, div_quo_q});
	assign quo_sat = sat_to32(quo_signed);

	assign sum_wide = 34'(term_p_q) + 34'(integral_q) + 34'(prod_q);
	assign sum_clamp = clamp_lim(sum_wide, limit_low, limit_high);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			prev_error_q <= '0;
			div_cnt_q <= '0;
			error_q <= '0;
			prod_q <= '0;
			term_p_q <= '0;
			deriv_q <= '0;
			drive_q <= '0;
			div_rem_q <= '0;
			div_num_q <= '0;
			div_quo_q <= '0;
			div_neg_q <= 1'b0;
		end else begin
			case (cmd.op)
				pidc_pkg::OP_LOAD: begin
					error_q <= err_sat;
				end
				pidc_pkg::OP_MUL_EDT, pidc_pkg::OP_MUL_INC, pidc_pkg::OP_MUL_D: begin
					prod_q <= mul_sat;
				end
				pidc_pkg::OP_INTEG: begin
					integral_q <= integ_clamp;
				end
				pidc_pkg::OP_DIV_START: begin
					div_num_q <= {diff_mag, 16'd0};
					div_rem_q <= '0;
					div_quo_q <= '0;
					div_neg_q <= diff[32];
					div_cnt_q <= '0;
				end
				pidc_pkg::OP_DIV_STEP: begin
					div_num_q <= {div_num_q[46:0], 1'b0};
					if (!rem_trial[48]) begin
						div_rem_q <= rem_trial[47:0];
						div_quo_q <= {div_quo_q[46:0], 1'b1};
					end else begin
						div_rem_q <= rem_shift[47:0];
						div_quo_q <= {div_quo_q[46:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q + 1'b1;
				end
				pidc_pkg::OP_DIV_END: begin
					deriv_q <= quo_sat;
				end
				pidc_pkg::OP_MUL_P: begin
					term_p_q <= mul_sat;
				end
				pidc_pkg::OP_SUM: begin
					drive_q <= sum_clamp;
					prev_error_q <= error_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign status.div_last = (div_cnt_q == 6'(pidc_pkg::DivBits - 1));
	assign drive = drive_q;

endmodule

/* src/pidc_control.sv */
// Sequencer of the PID controller: accepts a word, steps the datapath through
// its operations, and drives the result valid and load strobe. Uses pidc_pkg.
`timescale 1ns / 1ps

module pidc_control (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  load_out,
	output pidc_pkg::dp_cmd_t     cmd,
	input  pidc_pkg::dp_status_t  status
);

	typedef enum logic [3:0] {
		S_IDLE, S_EDT, S_INC, S_INTEG, S_DSTART, S_DSTEP, S_DEND, S_MULP, S_MULD, S_SUM,
		S_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign load_out = (state_q == S_OUT);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		case (state_q)
			S_IDLE:   cmd.op = (in_valid) ? pidc_pkg::OP_LOAD : pidc_pkg::OP_NONE;
			S_EDT:    cmd.op = pidc_pkg::OP_MUL_EDT;
			S_INC:    cmd.op = pidc_pkg::OP_MUL_INC;
			S_INTEG:  cmd.op = pidc_pkg::OP_INTEG;
			S_DSTART: cmd.op = pidc_pkg::OP_DIV_START;
			S_DSTEP:  cmd.op = pidc_pkg::OP_DIV_STEP;
			S_DEND:   cmd.op = pidc_pkg::OP_DIV_END;
			S_MULP:   cmd.op = pidc_pkg::OP_MUL_P;
			S_MULD:   cmd.op = pidc_pkg::OP_MUL_D;
			S_SUM:    cmd.op = pidc_pkg::OP_SUM;
			default:  cmd.op = pidc_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// The output register is free once the previous word has gone.
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_EDT;
				S_EDT:    state_q <= S_INC;
				S_INC:    state_q <= S_INTEG;
				S_INTEG:  state_q <= S_DSTART;
				S_DSTART: state_q <= S_DSTEP;
				S_DSTEP:  if (status.div_last) state_q <= S_DEND;
				S_DEND:   state_q <= S_MULP;
				S_MULP:   state_q <= S_MULD;
				S_MULD:   state_q <= S_SUM;
				S_SUM:    state_q <= S_OUT;
				S_OUT:    if (out_free) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready)
		else $error("input accepted while busy");
	a_out_after_sum: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("result raised outside output state");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEND) |-> $past(status.div_last))
		else $error("divider ended early");

endmodule

/* src/pid_controller_clamped.sv */
// Top level of the clamped PID controller: configuration registers, output
// register, and the sequencer and datapath. Uses pidc_pkg, pidc_stream_if,
// pidc_control and pidc_datapath.
//
// Usage: each input word holds measured (bits 31:0) and target (bits 63:32),
// both signed Q16.16, on the in_ch channel. Each accepted word yields one
// result word with drive (signed Q16.16) on out_ch.
// The 48-step restoring divider for the derivative takes most of the work on
// each word; one item is in work at a time, so no new word is taken until the
// result of the last one has been loaded into the output register.
// Configuration: the user must use cfg_we, cfg_index, cfg_data to write gains,
// time step and limits only while the block is idle; the block does not enforce it. Reset clears integral
// and stored error, sets the gains to zero, the time step to 1.0 and the limits to the full range.
// A stalled receiver holds the result word; the block finishes the next word
// and waits in its output state until the register is free.
`timescale 1ns / 1ps

module pid_controller_clamped (
	input  logic                                clk,
	input  logic                                arst_n,
	pidc_stream_if.sink                         in_ch,
	pidc_stream_if.source                       out_ch,
	input  logic                                cfg_we,
	input  logic [pidc_pkg::IndexW-1:0]         cfg_index,
	input  logic [pidc_pkg::DataW-1:0]          cfg_data
);

	logic signed [31:0] gain_p_q;
	logic signed [31:0] gain_i_q;
	logic signed [31:0] gain_d_q;
	logic [30:0]        time_step_q;
	logic signed [31:0] limit_low_q;
	logic signed [31:0] limit_high_q;
	logic signed [31:0] drive_q;
	logic signed [31:0] dp_drive;
	logic               load_out;
	pidc_pkg::dp_cmd_t    cmd;
	pidc_pkg::dp_status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			time_step_q <= 31'd65536;
			limit_low_q <= 32'sh80000000;
			limit_high_q <= 32'sh7fffffff;
		end else if (cfg_we) begin
			case (cfg_index)
				pidc_pkg::REG_GAIN_P:     gain_p_q <= cfg_data;
				pidc_pkg::REG_GAIN_I:     gain_i_q <= cfg_data;
				pidc_pkg::REG_GAIN_D:     gain_d_q <= cfg_data;
				pidc_pkg::REG_TIME_STEP:  time_step_q <= cfg_data[30:0];
				pidc_pkg::REG_LIMIT_LOW:  limit_low_q <= cfg_data;
				pidc_pkg::REG_LIMIT_HIGH: limit_high_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out && (!out_ch.valid || out_ch.ready)) begin
			drive_q <= dp_drive;
		end
	end

	assign out_ch.data = drive_q;

	pidc_control u_control (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.load_out  (load_out),
		.cmd       (cmd),
		.status    (status)
	);

	pidc_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.measured   (in_ch.data[31:0]),
		.target     (in_ch.data[63:32]),
		.gain_p     (gain_p_q),
		.gain_i     (gain_i_q),
		.gain_d     (gain_d_q),
		.time_step  (time_step_q),
		.limit_low  (limit_low_q),
		.limit_high (limit_high_q),
		.drive      (dp_drive)
	);

endmodule

/* tb/pid_controller_clamped_tb.sv */
// Self-checking testbench for pid_controller_clamped: drives random and corner
// measured/target words, predicts each drive word, and checks results in order.
// Depends on pidc_pkg, pidc_stream_if and the pid_controller_clamped RTL.
`timescale 1ns / 1ps

class pid_drive_scoreboard;
	int gain_p, gain_i, gain_d, limit_low, limit_high;
	bit [30:0] time_step;
	int integral_sum, previous_error;
	int expected_drive[$];
	int mismatches;

	function void clear();
		gain_p = 0;
		gain_i = 0;
		gain_d = 0;
		time_step = 31'd65536;
		limit_low = 32'sh8000_0000;
		limit_high = 32'sh7fff_ffff;
		integral_sum = 0;
		previous_error = 0;
		expected_drive.delete();
		mismatches = 0;
	endfunction

	function void write_reg(logic [2:0] index, logic [31:0] value);
		case (index)
			pidc_pkg::REG_GAIN_P: gain_p = value;
			pidc_pkg::REG_GAIN_I: gain_i = value;
			pidc_pkg::REG_GAIN_D: gain_d = value;
			pidc_pkg::REG_TIME_STEP: time_step = value[30:0];
			pidc_pkg::REG_LIMIT_LOW: limit_low = value;
			pidc_pkg::REG_LIMIT_HIGH: limit_high = value;
			default: ;
		endcase
	endfunction

	function int saturate(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fff_ffff;
		if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		return int'(v);
	endfunction

	// Q16.16 product, rounded toward minus infinity.
	function int fixed_mul(int a, int b);
		longint p;
		p = longint'(a) * longint'(b);
		return saturate(p >>> 16);
	endfunction

	// The high limit is tested first; when the limits cross, values above it take it and all others the low limit.
	function int clamp(longint v);
		if (v > longint'(limit_high))
			return limit_high;
		if (v < longint'(limit_low))
			return limit_low;
		return int'(v);
	endfunction

	function void note_input(int measured, int target);
		longint dt, diff, total;
		int err, incr, deriv;
		dt = (time_step == 0) ? 64'sd1 : longint'(time_step);
		err = saturate(longint'(target) - longint'(measured));
		incr = fixed_mul(fixed_mul(err, int'(dt)), gain_i);
		integral_sum = clamp(longint'(saturate(longint'(integral_sum) + longint'(incr))));
		diff = longint'(err) - longint'(previous_error);
		deriv = saturate((diff * 64'sd65536) / dt);
		total = longint'(fixed_mul(gain_p, err)) + longint'(integral_sum)
			+ longint'(fixed_mul(gain_d, deriv));
		expected_drive.push_back(clamp(total));
		previous_error = err;
	endfunction

	function void check_result(int drive);
		int want;
		if (expected_drive.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected drive word %0d", drive);
			return;
		end
		want = expected_drive.pop_front();
		if (want != drive) begin
			mismatches++;
			if (mismatches <= 10)
				$display("drive mismatch: expected %0d, got %0d", want, drive);
		end
	endfunction
endclass

module pid_controller_clamped_tb;

	localparam logic [pidc_pkg::IndexW-1:0] SPARE_INDEX_A = 3'd6;
	localparam logic [pidc_pkg::IndexW-1:0] SPARE_INDEX_B = 3'd7;
	localparam int QONE = 65536;
	localparam int INT_MIN = 32'sh8000_0000;
	localparam int INT_MAX = 32'sh7fff_ffff;
	localparam int SETTLE_CYCLES = 70;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [pidc_pkg::IndexW-1:0] cfg_index = '0;
	logic [pidc_pkg::DataW-1:0] cfg_data = '0;

	pidc_stream_if #(.Width(64)) in_ch ();
	pidc_stream_if #(.Width(32)) out_ch ();

	pid_drive_scoreboard drive_sb = new();

	pid_controller_clamped dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
	end

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function int pick_value();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
			2: return int'($urandom_range(0, 1 << 26)) - (1 << 25);
			3: begin
				case ($urandom_range(0, 3))
					0: return INT_MIN;
					1: return INT_MAX;
					2: return 0;
					default: return -1;
				endcase
			end
			default: return int'($urandom_range(0, 200 * QONE)) - 100 * QONE;
		endcase
	endfunction

	// Receiver: bursts of ready, stalls of random length, occasional long open stretches.
	initial begin
		@(posedge arst_n);
		forever begin
			int stall;
			stall = pick_gap();
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			repeat ($urandom_range(0, 9) == 0 ? $urandom_range(200, 800)
				: $urandom_range(1, 4)) @(posedge clk);
		end
	end

	always @(posedge clk)
		if (arst_n && out_ch.valid && out_ch.ready)
			drive_sb.check_result(int'(out_ch.data));

	task automatic send_word(int measured, int target, bit pause);
		int gap;
		in_ch.valid <= 1'b1;
		in_ch.data <= {target, measured};
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		drive_sb.note_input(measured, target);
		gap = pause ? pick_gap() : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (drive_sb.expected_drive.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [pidc_pkg::IndexW-1:0] index,
			logic [pidc_pkg::DataW-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		drive_sb.write_reg(index, value);
	endtask

	task automatic configure(int gp, int gi, int gd, logic [31:0] step, int lo, int hi);
		write_reg(pidc_pkg::REG_GAIN_P, gp);
		write_reg(pidc_pkg::REG_GAIN_I, gi);
		write_reg(pidc_pkg::REG_GAIN_D, gd);
		write_reg(pidc_pkg::REG_TIME_STEP, step);
		write_reg(pidc_pkg::REG_LIMIT_LOW, lo);
		write_reg(pidc_pkg::REG_LIMIT_HIGH, hi);
		// Writes to unused indexes must leave every register alone.
		write_reg(SPARE_INDEX_A, $urandom);
		write_reg(SPARE_INDEX_B, $urandom);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_items(int count);
		repeat (count) begin
			int m;
			m = pick_value();
			// Mostly setpoints near the measurement so the integral builds gradually.
			if ($urandom_range(0, 2) == 0)
				send_word(m, pick_value(), 1'b1);
			else
				send_word(m, m + int'($urandom_range(0, 20 * QONE)) - 10 * QONE, 1'b1);
		end
	endtask

	task automatic directed_items();
		send_word(INT_MIN, INT_MAX, 1'b0);
		send_word(INT_MAX, INT_MIN, 1'b0);
		send_word(0, 0, 1'b1);
		send_word(INT_MAX, INT_MAX, 1'b0);
		send_word(INT_MIN, INT_MIN, 1'b1);
		send_word(-1, 0, 1'b0);
		send_word(0, -1, 1'b0);
		send_word(INT_MAX, -1, 1'b1);
		send_word(INT_MIN, 1, 1'b0);
		send_word(32'h5555_5555, 32'haaaa_aaaa, 1'b0);
		send_word(32'haaaa_aaaa, 32'h5555_5555, 1'b1);
		send_word(QONE, 3 * QONE, 1'b0);
	endtask

	initial begin
		drive_sb.clear();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: zero gains give a zero drive.
		directed_items();
		random_items(40);
		wait_idle();

		configure(QONE, QONE / 2, QONE / 10, 66, -100 * QONE, 100 * QONE);
		directed_items();
		random_items(250);
		wait_idle();

		// Largest gains and step, full range.
		configure(INT_MAX, INT_MAX, INT_MAX, 32'hffff_ffff, INT_MIN, INT_MAX);
		directed_items();
		random_items(150);
		wait_idle();

		// Most negative gains; a zero step is taken as the smallest step.
		configure(INT_MIN, INT_MIN, INT_MIN, 32'h8000_0000, -QONE, QONE);
		directed_items();
		random_items(150);
		wait_idle();

		// Crossed limits: the high limit is tested first.
		configure(2 * QONE, QONE / 4, QONE, 1, 50 * QONE, -50 * QONE);
		random_items(150);
		wait_idle();

		configure(3 * QONE, QONE, -QONE / 2, QONE, 0, 0);
		random_items(100);
		wait_idle();

		repeat (4) begin
			int lo, hi;
			lo = pick_value();
			hi = pick_value();
			if ($urandom_range(0, 3) != 0 && lo > hi) begin
				int t;
				t = lo;
				lo = hi;
				hi = t;
			end
			configure(pick_value(), pick_value(), pick_value(), $urandom, lo, hi);
			random_items(140);
			wait_idle();
		end

		if (drive_sb.mismatches == 0 && drive_sb.expected_drive.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#4000000;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
